[rtl/core/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared constants, tables and types of the space-vector PWM duty block.
// ----------------------------------------------------------------------------
package svpd_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int DUTY_BITS_DEF  = 16;
  localparam int CORDIC_STEPS   = 28;
  localparam int VSCALE_BITS    = 16;

  // Inverse CORDIC gain (Q30) and sqrt(3)/2 (Q30), each split into 15-bit halves.
  localparam logic [29:0] KINV_Q30       = 30'd652032874;
  localparam logic [29:0] HALF_SQRT3_Q30 = 30'd929887697;
  localparam logic [14:0] KINV_HI        = KINV_Q30[29:15];
  localparam logic [14:0] KINV_LO        = KINV_Q30[14:0];
  localparam logic [14:0] HSQ3_HI        = HALF_SQRT3_Q30[29:15];
  localparam logic [14:0] HSQ3_LO        = HALF_SQRT3_Q30[14:0];

  localparam logic [13:0] SUPPLY_RESET = 14'd12288;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SUPPLY = 1'b0;

  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  // Arctangent of 2^-i as a Q32 fraction of a turn.
  localparam logic signed [31:0] TURN_ATAN [0:CORDIC_STEPS-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
    32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
    32'sd651,       32'sd325,       32'sd162,       32'sd81,
    32'sd40,        32'sd20,        32'sd10,        32'sd5
  };

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
    logic        clipped;
  } svpd_result_t;

  // Sign placement per sector: bit 2*ph negates n1, bit 2*ph+1 negates n2.
  function automatic logic [5:0] place_neg(input logic [2:0] sec);
    logic [5:0] r;
    r = 6'b000000;
    unique case (sec)
      3'd0:    r = 6'b110100;
      3'd1:    r = 6'b110010;
      3'd2:    r = 6'b010011;
      3'd3:    r = 6'b001011;
      3'd4:    r = 6'b001101;
      3'd5:    r = 6'b101100;
      default: r = 6'b000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/svpd_datapath.sv]
// ----------------------------------------------------------------------------
// svpd_datapath
// Pipelined inverse Park rotation, sector search and duty division.
// ----------------------------------------------------------------------------
module svpd_datapath #(
  parameter int ANGLE_BITS = svpd_pkg::ANGLE_BITS_DEF,
  parameter int DUTY_BITS  = svpd_pkg::DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [14:0]   in_vq,
  input  logic signed [14:0]   in_vd,
  input  logic [15:0]          in_angle,
  input  logic [13:0]          supply,
  output logic                 tail_valid,
  output svpd_pkg::svpd_result_t tail
);

  localparam int AB = ANGLE_BITS;
  localparam int DB = DUTY_BITS;
  localparam int CS = svpd_pkg::CORDIC_STEPS;
  localparam int XW = 34;
  localparam int UW = 34;
  localparam int QW = 36;
  localparam int GW = 39;
  localparam int NW = 41;
  localparam int OB = 16;
  localparam logic [AB-1:0] EIGHTH  = AB'(1) << (AB - 3);
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic [DB-1:0] FULL    = {DB{1'b1}};

  // Angle reduction and quarter-turn swap in front of the CORDIC.
  logic [AB+15:0]        theta_w;
  logic [AB-1:0]         theta, theta_q, rr, phi;
  logic [1:0]            quad;
  logic [AB+2:0]         phi6;
  logic signed [XW-1:0]  xs, ys, x0, y0;

  assign theta_w = {in_angle, {AB{1'b0}}};
  assign theta   = theta_w[AB+15:16];
  assign theta_q = theta + EIGHTH;
  assign quad    = theta_q[AB-1:AB-2];
  assign rr      = theta - {quad, {(AB-2){1'b0}}};
  assign phi     = theta + QUARTER;
  assign phi6    = {1'b0, phi, 2'b00} + {2'b00, phi, 1'b0};
  assign xs      = XW'(in_vd) <<< svpd_pkg::VSCALE_BITS;
  assign ys      = XW'(in_vq) <<< svpd_pkg::VSCALE_BITS;

  always_comb begin
    unique case (quad)
      2'd0: begin x0 = xs;  y0 = ys;  end
      2'd1: begin x0 = -ys; y0 = xs;  end
      2'd2: begin x0 = -xs; y0 = -ys; end
      default: begin x0 = ys; y0 = -xs; end
    endcase
  end

  // CORDIC rotation, one step per stage.
  logic signed [XW-1:0] cx_r [0:CS];
  logic signed [XW-1:0] cy_r [0:CS];
  logic signed [31:0]   cz_r [0:CS];
  logic [2:0]           ck_r [0:CS];
  logic                 cnz_r [0:CS];
  logic                 cv_r [0:CS];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= x0;
      cy_r[0]  <= y0;
      cz_r[0]  <= $signed({rr, {(32-AB){1'b0}}});
      ck_r[0]  <= phi6[AB+2:AB];
      cnz_r[0] <= (in_vd != 15'sd0);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CS; gi++) begin : g_cordic
      logic signed [XW-1:0] dx, dy;
      // Each coordinate moves by the other one shifted down.
      assign dx = cy_r[gi] >>> gi;
      assign dy = cx_r[gi] >>> gi;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz_r[gi][31]) begin
            cx_r[gi+1] <= cx_r[gi] - dx;
            cy_r[gi+1] <= cy_r[gi] + dy;
            cz_r[gi+1] <= cz_r[gi] - svpd_pkg::TURN_ATAN[gi];
          end else begin
            cx_r[gi+1] <= cx_r[gi] + dx;
            cy_r[gi+1] <= cy_r[gi] - dy;
            cz_r[gi+1] <= cz_r[gi] + svpd_pkg::TURN_ATAN[gi];
          end
          ck_r[gi+1]  <= ck_r[gi];
          cnz_r[gi+1] <= cnz_r[gi];
        end
      end
    end
  endgenerate

  // Gain removal and the sqrt(3) scaling, each as two partial products.
  logic signed [XW+15:0] ga_xh_r, ga_xl_r, ga_yh_r, ga_yl_r;
  logic signed [UW-1:0]  gb_u_r, gb_w_r;
  logic signed [QW-1:0]  qa_p2_r, qb_p2_r, qb_q2_r;
  logic signed [UW+15:0] qa_wh_r, qa_wl_r;
  logic [2:0]            ga_k_r, gb_k_r, qa_k_r, qb_k_r;
  logic                  ga_nz_r, gb_nz_r, qa_nz_r, qb_nz_r;
  logic                  ga_v_r, gb_v_r, qa_v_r, qb_v_r;
  logic signed [XW+30:0] u_full, w_full;
  logic signed [UW+30:0] q2_full;

  assign u_full  = ((XW+31)'(ga_xh_r) <<< 15) + (XW+31)'(ga_xl_r);
  assign w_full  = ((XW+31)'(ga_yh_r) <<< 15) + (XW+31)'(ga_yl_r);
  assign q2_full = ((UW+31)'(qa_wh_r) <<< 15) + (UW+31)'(qa_wl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ga_xh_r <= cx_r[CS] * $signed({1'b0, svpd_pkg::KINV_HI});
      ga_xl_r <= cx_r[CS] * $signed({1'b0, svpd_pkg::KINV_LO});
      ga_yh_r <= cy_r[CS] * $signed({1'b0, svpd_pkg::KINV_HI});
      ga_yl_r <= cy_r[CS] * $signed({1'b0, svpd_pkg::KINV_LO});
      ga_k_r  <= ck_r[CS];
      ga_nz_r <= cnz_r[CS];
      gb_u_r  <= UW'(u_full >>> 30);
      gb_w_r  <= UW'(w_full >>> 30);
      gb_k_r  <= ga_k_r;
      gb_nz_r <= ga_nz_r;
      qa_p2_r <= QW'(gb_u_r) + (QW'(gb_u_r) <<< 1);
      qa_wh_r <= gb_w_r * $signed({1'b0, svpd_pkg::HSQ3_HI});
      qa_wl_r <= gb_w_r * $signed({1'b0, svpd_pkg::HSQ3_LO});
      qa_k_r  <= gb_k_r;
      qa_nz_r <= gb_nz_r;
      qb_p2_r <= qa_p2_r;
      qb_q2_r <= QW'(q2_full >>> 29);
      qb_k_r  <= qa_k_r;
      qb_nz_r <= qa_nz_r;
    end
  end

  // Edge terms, sector choice and numerators.
  logic signed [GW-1:0] g_r [0:5];
  logic [2:0]           g_k_r;
  logic                 g_nz_r, g_v_r;
  logic signed [GW-1:0] p2e, q2e;

  assign p2e = GW'(qb_p2_r);
  assign q2e = GW'(qb_q2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0] <= -(q2e <<< 1);
      g_r[1] <= p2e - q2e;
      g_r[2] <= p2e + q2e;
      g_r[3] <= q2e <<< 1;
      g_r[4] <= q2e - p2e;
      g_r[5] <= -p2e - q2e;
      g_k_r  <= qb_k_r;
      g_nz_r <= qb_nz_r;
    end
  end

  logic [2:0]           sel_sec;
  logic                 sel_found;
  logic signed [GW-1:0] sel_n1, sel_n2;

  always_comb begin
    sel_found = 1'b0;
    sel_sec   = 3'd0;
    // Lowest sector whose edge test passes wins.
    for (int i = 6; i >= 1; i--) begin
      if ((g_r[i % 6] > 0) && (g_r[i-1] <= 0)) begin
        sel_found = 1'b1;
        sel_sec   = 3'(i - 1);
      end
    end
    if (!(g_nz_r && sel_found)) begin
      sel_sec = g_k_r;
    end
    unique case (sel_sec)
      3'd0: begin sel_n1 = g_r[1]; sel_n2 = -g_r[0]; end
      3'd1: begin sel_n1 = g_r[2]; sel_n2 = -g_r[1]; end
      3'd2: begin sel_n1 = g_r[3]; sel_n2 = -g_r[2]; end
      3'd3: begin sel_n1 = g_r[4]; sel_n2 = -g_r[3]; end
      3'd4: begin sel_n1 = g_r[5]; sel_n2 = -g_r[4]; end
      3'd5: begin sel_n1 = g_r[0]; sel_n2 = -g_r[5]; end
      default: begin sel_n1 = '0; sel_n2 = '0; end
    endcase
  end

  logic signed [GW-1:0] s_n1_r, s_n2_r;
  logic [2:0]           s_sec_r, n_sec_r, f_sec_r;
  logic                 s_v_r, n_v_r, f_v_r;
  logic signed [NW-1:0] n_num_r [0:2];
  logic [5:0]           neg;
  logic signed [NW-1:0] den_s, den2_s;

  assign neg    = svpd_pkg::place_neg(s_sec_r);
  assign den_s  = $signed({{(NW-31){1'b0}}, supply, 17'b0});
  assign den2_s = $signed({{(NW-32){1'b0}}, supply, 18'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      s_n1_r  <= sel_n1;
      s_n2_r  <= sel_n2;
      s_sec_r <= sel_sec;
      for (int ph = 0; ph < 3; ph++) begin
        n_num_r[ph] <= den_s
                     + (neg[2*ph]   ? -NW'(s_n1_r) : NW'(s_n1_r))
                     + (neg[2*ph+1] ? -NW'(s_n2_r) : NW'(s_n2_r));
      end
      n_sec_r <= s_sec_r;
    end
  end

  // Saturation test, then num * F scaled down for the divider.
  logic [31:0] f_mid_r [0:2];
  logic        f_zero_r [0:2];
  logic        f_full_r [0:2];
  logic        f_clip_r;
  logic        f_clip_nxt;

  always_comb begin
    f_clip_nxt = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      if ((n_num_r[ph] < 0) || (n_num_r[ph] > den2_s)) begin
        f_clip_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_clip_r <= f_clip_nxt;
      for (int ph = 0; ph < 3; ph++) begin
        f_zero_r[ph] <= (n_num_r[ph] <= 0);
        f_full_r[ph] <= (n_num_r[ph] >= den2_s);
        f_mid_r[ph]  <= ((n_num_r[ph] > 0) && (n_num_r[ph] < den2_s)) ?
                        n_num_r[ph][31:0] : 32'd0;
      end
      f_sec_r <= n_sec_r;
    end
  end

  // First divider: floor(num * F / 2^18) by the supply word, one bit a stage.
  logic [13:0]   d1_rem_r  [0:DB][0:2];
  logic [DB-1:0] d1_low_r  [0:DB][0:2];
  logic [DB-1:0] d1_q_r    [0:DB][0:2];
  logic          d1_zero_r [0:DB][0:2];
  logic          d1_full_r [0:DB][0:2];
  logic [2:0]    d1_sec_r  [0:DB];
  logic          d1_clip_r [0:DB];
  logic          d1_v_r    [0:DB];
  logic [31+DB:0] mprod [0:2];

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      mprod[ph] = f_mid_r[ph] * FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ph = 0; ph < 3; ph++) begin
        d1_rem_r[0][ph]  <= mprod[ph][31+DB:18+DB];
        d1_low_r[0][ph]  <= mprod[ph][17+DB:18];
        d1_q_r[0][ph]    <= '0;
        d1_zero_r[0][ph] <= f_zero_r[ph];
        d1_full_r[0][ph] <= f_full_r[ph];
      end
      d1_sec_r[0]  <= f_sec_r;
      d1_clip_r[0] <= f_clip_r;
    end
  end

  generate
    for (gi = 0; gi < DB; gi++) begin : g_div1
      logic [14:0] trial [0:2];
      logic        take  [0:2];
      always_comb begin
        for (int ph = 0; ph < 3; ph++) begin
          trial[ph] = {d1_rem_r[gi][ph], d1_low_r[gi][ph][DB-1]};
          take[ph]  = (trial[ph] >= {1'b0, supply});
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          for (int ph = 0; ph < 3; ph++) begin
            d1_rem_r[gi+1][ph]  <= take[ph] ? 14'(trial[ph] - {1'b0, supply})
                                            : trial[ph][13:0];
            d1_low_r[gi+1][ph]  <= d1_low_r[gi][ph] << 1;
            d1_q_r[gi+1][ph]    <= {d1_q_r[gi][ph][DB-2:0], take[ph]};
            d1_zero_r[gi+1][ph] <= d1_zero_r[gi][ph];
            d1_full_r[gi+1][ph] <= d1_full_r[gi][ph];
          end
          d1_sec_r[gi+1]  <= d1_sec_r[gi];
          d1_clip_r[gi+1] <= d1_clip_r[gi];
        end
      end
    end
  endgenerate

  // Output rescale: duty * 65535 / F through a truncated reciprocal. The
  // estimate is never high and at most one low, so a single compare and
  // subtract in the next stage settles it.
  localparam int PW = DB + OB;
  localparam logic [16:0] RECIP = 17'((64'd65535 << DB) / ((64'd1 << DB) - 64'd1));

  logic [DB-1:0]  duty_d  [0:2];
  logic [DB+16:0] est_p   [0:2];
  logic [PW-1:0]  r_x_r   [0:2];
  logic [OB-1:0]  r_est_r [0:2];
  logic [2:0]     r_sec_r, o_sec_r;
  logic           r_clip_r, o_clip_r;
  logic           r_v_r, o_v_r;
  logic [PW-1:0]  back    [0:2];
  logic [PW-1:0]  resid   [0:2];
  logic [OB-1:0]  o_q_r   [0:2];

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      if (d1_zero_r[DB][ph]) begin
        duty_d[ph] = '0;
      end else if (d1_full_r[DB][ph]) begin
        duty_d[ph] = FULL;
      end else begin
        duty_d[ph] = d1_q_r[DB][ph];
      end
      est_p[ph] = (DB+17)'(duty_d[ph]) * (DB+17)'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ph = 0; ph < 3; ph++) begin
        r_x_r[ph]   <= {duty_d[ph], {OB{1'b0}}} - PW'(duty_d[ph]);
        r_est_r[ph] <= est_p[ph][DB+OB-1:DB];
      end
      r_sec_r  <= d1_sec_r[DB];
      r_clip_r <= d1_clip_r[DB];
    end
  end

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      back[ph]  = (PW'(r_est_r[ph]) << DB) - PW'(r_est_r[ph]);
      resid[ph] = r_x_r[ph] - back[ph];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ph = 0; ph < 3; ph++) begin
        o_q_r[ph] <= r_est_r[ph] + OB'(resid[ph] >= PW'(FULL));
      end
      o_sec_r  <= r_sec_r;
      o_clip_r <= r_clip_r;
    end
  end

  // Valid bits travel alongside the payload and advance with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CS; i++) cv_r[i] <= 1'b0;
      ga_v_r <= 1'b0;
      gb_v_r <= 1'b0;
      qa_v_r <= 1'b0;
      qb_v_r <= 1'b0;
      g_v_r  <= 1'b0;
      s_v_r  <= 1'b0;
      n_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      for (int i = 0; i <= DB; i++) d1_v_r[i] <= 1'b0;
      r_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_valid;
      for (int i = 1; i <= CS; i++) cv_r[i] <= cv_r[i-1];
      ga_v_r <= cv_r[CS];
      gb_v_r <= ga_v_r;
      qa_v_r <= gb_v_r;
      qb_v_r <= qa_v_r;
      g_v_r  <= qb_v_r;
      s_v_r  <= g_v_r;
      n_v_r  <= s_v_r;
      f_v_r  <= n_v_r;
      d1_v_r[0] <= f_v_r;
      for (int i = 1; i <= DB; i++) d1_v_r[i] <= d1_v_r[i-1];
      r_v_r  <= d1_v_r[DB];
      o_v_r  <= r_v_r;
    end
  end

  assign tail_valid     = o_v_r;
  assign tail.duty_a    = o_q_r[0];
  assign tail.duty_b    = o_q_r[1];
  assign tail.duty_c    = o_q_r[2];
  assign tail.sector    = o_sec_r;
  assign tail.clipped   = o_clip_r;

endmodule

[rtl/core/svpwm_phase_duty.sv]
// ----------------------------------------------------------------------------
// svpwm_phase_duty
// Inverse Park rotation and space-vector PWM duty generation, fully pipelined.
// ----------------------------------------------------------------------------
// The input stream carries one word per PWM update: a q-axis and a d-axis
// voltage and an electrical angle. The block rotates the voltage vector by
// the angle, finds its sixty-degree sector, splits the zero time evenly and
// returns the three phase duties, the sector and a saturation flag as one
// output word.
// The pipeline takes one word every cycle unless the skid entry is full. Its
// depth is set by the 28-step CORDIC and the bit-per-stage supply divider,
// and the reciprocal rescale to the 16-bit output adds two stages.
// The supply voltage register sits on the APB port and should only be
// written while no word is in flight.
// Reset empties the pipeline and loads a 12 V supply. When the receiver
// stalls, a two-entry output buffer keeps accepting, then the whole
// pipeline freezes in place; no word is dropped or repeated.
// ----------------------------------------------------------------------------
module svpwm_phase_duty #(
  parameter int ANGLE_BITS = svpd_pkg::ANGLE_BITS_DEF,
  parameter int DUTY_BITS  = svpd_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: volt_q[14:0], volt_d[29:15], elec_angle[45:30], zero pad.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [svpd_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: duty_a[15:0], duty_b[31:16], duty_c[47:32], sector[50:48], pad.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [svpd_pkg::OUT_W-1:0]      out_tdata,
  // out_tuser: clipped.
  output logic                            out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [svpd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  // Configuration register.
  logic [13:0] supply_r, supply_nxt;
  logic [13:0] supply_eff;
  logic        reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == svpd_pkg::REG_SUPPLY);
  assign cfg_prdata = reg_hit ? {18'd0, supply_r} : 32'd0;

  always_comb begin
    supply_nxt = supply_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      supply_nxt = cfg_pwdata[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= svpd_pkg::SUPPLY_RESET;
    end else begin
      supply_r <= supply_nxt;
    end
  end

  // A zero supply is treated as the smallest nonzero value.
  assign supply_eff = (supply_r == 14'd0) ? 14'd1 : supply_r;

  // The pipeline runs whenever the spare output entry is free.
  logic                   pipe_en;
  logic                   tail_valid;
  svpd_pkg::svpd_result_t tail;

  svpd_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_valid   (in_tvalid),
    .in_vq      ($signed(in_tdata[14:0])),
    .in_vd      ($signed(in_tdata[29:15])),
    .in_angle   (in_tdata[45:30]),
    .supply     (supply_eff),
    .tail_valid (tail_valid),
    .tail       (tail)
  );

  // Output register plus a skid entry. The pipeline stops only when both
  // are full, so the stall signal toward the input is a register.
  svpd_pkg::svpd_result_t out_r, out_nxt, skid_r, skid_nxt;
  logic                   out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic                   push, pop;

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;
  assign push      = pipe_en && tail_valid;
  assign pop       = out_v_r && out_tready;

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (pop || !out_v_r) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = tail;
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = tail;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_r.sector, out_r.duty_c, out_r.duty_b, out_r.duty_a};
  assign out_tuser  = out_r.clipped;

endmodule

[tb/svpwm_phase_duty_tb.sv]
// ----------------------------------------------------------------------------
// svpwm_phase_duty_tb
// Self-checking regression of the space-vector PWM duty pipeline.
// ----------------------------------------------------------------------------
// Voltage/angle words are streamed into the block and each result word is
// checked field by field against a behavioral duty predictor kept in this
// file. The run moves through several supply settings, including both
// extremes and zero, and through phases with and without idling on either
// side of the stream.
// ----------------------------------------------------------------------------
module svpwm_phase_duty_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [svpd_pkg::CFG_ADDR_W-1:0] SUPPLY_ADDR =
    svpd_pkg::CFG_ADDR_W'(4 * svpd_pkg::REG_SUPPLY);
  // Waits after a drain leave a margin over the pipeline latency.
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [14:0]            q;
    logic [14:0]            d;
    logic [15:0]            a;
    bit                     fixed;
    svpd_pkg::svpd_result_t res;
  } stim_row_t;

  // Sign applied to n1 and n2 for each phase, per sector.
  localparam int PLACE_SIGN [0:5][0:2][0:1] = '{
    '{'{ 1,  1}, '{-1,  1}, '{-1, -1}},
    '{'{ 1, -1}, '{ 1,  1}, '{-1, -1}},
    '{'{-1, -1}, '{ 1,  1}, '{-1,  1}},
    '{'{-1, -1}, '{ 1, -1}, '{ 1,  1}},
    '{'{-1,  1}, '{-1, -1}, '{ 1,  1}},
    '{'{ 1,  1}, '{-1, -1}, '{ 1, -1}}
  };

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [svpd_pkg::IN_W-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [svpd_pkg::OUT_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [svpd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  svpd_pkg::svpd_result_t duty_expect_q[$];
  logic [13:0]  supply_model;
  idle_mode_t   idle_mode;
  bit           hold_go;
  int           fail_count;

  svpwm_phase_duty uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // Duty predictor: rotates (vd, vq) by the angle with the same CORDIC
  // arithmetic the block uses, picks the sector and places the zero time.
  function automatic svpd_pkg::svpd_result_t svpwm_duty(input logic [14:0] q,
                                                        input logic [14:0] d,
                                                        input logic [15:0] ang,
                                                        input logic [13:0] vsup);
    longint vq, vd, theta, quad, r, x, y, z, t, dx, dy, u, w, p2, q2;
    longint n1, n2, den, num, duty, k, phi;
    longint g [0:5];
    bit clip;
    svpd_pkg::svpd_result_t res;
    vq = longint'($signed(q));
    vd = longint'($signed(d));
    theta = longint'(ang);
    quad = ((theta + 8192) >> 14) & 3;
    r = (theta - quad * 16384) & 65535;
    if (r >= 32768) r = r - 65536;
    z = r * 65536;
    x = vd * 65536;
    y = vq * 65536;
    // Quarter turns are exact swaps; the CORDIC only handles the residual.
    for (int i = 0; i < quad; i++) begin
      t = x;
      x = -y;
      y = t;
    end
    for (int i = 0; i < svpd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(svpd_pkg::TURN_ATAN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(svpd_pkg::TURN_ATAN[i]);
      end
    end
    u = (x * 64'sd652032874) >>> 30;
    w = (y * 64'sd652032874) >>> 30;
    p2 = 3 * u;
    q2 = (w * 64'sd929887697) >>> 29;
    g[0] = -2 * q2;
    g[1] = p2 - q2;
    g[2] = p2 + q2;
    g[3] = 2 * q2;
    g[4] = q2 - p2;
    g[5] = -p2 - q2;
    k = 0;
    if (vd != 0) begin
      for (int i = 1; i <= 6; i++)
        if (k == 0 && g[i % 6] > 0 && -g[i - 1] >= 0) k = i;
    end
    // Without a d component, or with no sector passing, fall back to the angle.
    if (k == 0) begin
      phi = (theta + 16384) & 65535;
      k = ((phi * 6) >> 16) + 1;
    end
    n1 = g[k % 6];
    n2 = -g[k - 1];
    den = longint'((vsup == 0) ? 14'd1 : vsup) << 17;
    clip = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      num = den + PLACE_SIGN[k - 1][ph][0] * n1 + PLACE_SIGN[k - 1][ph][1] * n2;
      if (num <= 0) begin
        if (num < 0) clip = 1'b1;
        duty = 0;
      end else if (num >= 2 * den) begin
        if (num > 2 * den) clip = 1'b1;
        duty = 65535;
      end else begin
        duty = (num * 65535) / (2 * den);
      end
      case (ph)
        0: res.duty_a = duty[15:0];
        1: res.duty_b = duty[15:0];
        default: res.duty_c = duty[15:0];
      endcase
    end
    res.sector = 3'(k - 1);
    res.clipped = clip;
    return res;
  endfunction

  // Offers one word and waits for it to be taken, then records what it should give.
  task automatic send_word(input logic [14:0] q, input logic [14:0] d,
                           input logic [15:0] a, input bit fixed,
                           input svpd_pkg::svpd_result_t fixed_res);
    int pct;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, a, d, q};
    do @(posedge clk); while (!in_tready);
    duty_expect_q.push_back(fixed ? fixed_res : svpwm_duty(q, d, a, supply_model));
    pct = (idle_mode == IDLE_SEND) ? 85 : (idle_mode == IDLE_BOTH) ? 24 : 0;
    // Each following cycle stays idle with the same odds.
    if ($urandom_range(99) < pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain_results();
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the supply register and reads it back.
  task automatic write_supply(input logic [13:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SUPPLY_ADDR;
    cfg_pwdata  <= {18'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    supply_model = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[13:0] !== value) begin
      $display("%0t supply readback: expected %0d actual %0d", $realtime, value,
               cfg_prdata[13:0]);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random word: mid-range and full-range vectors, some with no d part, some at the rails.
  task automatic random_word(output logic [14:0] q, output logic [14:0] d,
                             output logic [15:0] a);
    int pick;
    pick = $urandom_range(99);
    a = 16'($urandom);
    if (pick < 15) begin
      q = 15'($urandom);
      d = 15'd0;
    end else if (pick < 25) begin
      q = $urandom_range(1) ? 15'h3FFF : 15'h4000;
      d = $urandom_range(1) ? 15'h3FFF : 15'h4000;
    end else if (pick < 60) begin
      q = 15'($signed(16'($urandom_range(0, 8000)) - 16'sd4000));
      d = 15'($signed(16'($urandom_range(0, 8000)) - 16'sd4000));
    end else begin
      q = 15'($urandom);
      d = 15'($urandom);
    end
  endtask

  // Long holds are counted here so that the sender keeps pushing meanwhile.
  int hold_left;
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_tready <= ($urandom_range(99) >= 85);
    end else if (idle_mode == IDLE_BOTH) begin
      out_tready <= ($urandom_range(99) >= 24);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin
    svpd_pkg::svpd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (duty_expect_q.size() == 0) begin
        $display("%0t unexpected result word: actual %h user %b", $realtime, out_tdata,
                 out_tuser);
        fail_count++;
      end else begin
        want = duty_expect_q.pop_front();
        if (out_tdata[15:0] !== want.duty_a || out_tdata[31:16] !== want.duty_b ||
            out_tdata[47:32] !== want.duty_c || out_tdata[50:48] !== want.sector ||
            out_tuser !== want.clipped) begin
          $display("%0t mismatch: expected a=%0d b=%0d c=%0d sec=%0d clip=%0b", $realtime,
                   want.duty_a, want.duty_b, want.duty_c, want.sector, want.clipped);
          $display("%0t          actual   a=%0d b=%0d c=%0d sec=%0d clip=%0b", $realtime,
                   out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[50:48],
                   out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t dir_rows [0:21];
    logic [14:0] rq, rd;
    logic [15:0] ra;
    logic [13:0] supplies [0:5];
    idle_mode_t  modes [0:5];
    svpd_pkg::svpd_result_t none;
    none = '0;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_go = 1'b0;
    hold_left = 0;
    fail_count = 0;
    idle_mode = IDLE_NONE;
    supply_model = svpd_pkg::SUPPLY_RESET;

    // A zero vector always lands at half duty, rounded down; its sector then
    // follows from the angle alone.
    dir_rows = '{
      '{15'd0,      15'd0,      16'd0,     1'b1, '{16'd32767, 16'd32767, 16'd32767, 3'd1, 1'b0}},
      '{15'd0,      15'd0,      16'd32768, 1'b1, '{16'd32767, 16'd32767, 16'd32767, 3'd4, 1'b0}},
      '{15'd0,      15'd0,      16'd65535, 1'b1, '{16'd32767, 16'd32767, 16'd32767, 3'd1, 1'b0}},
      '{15'h3FFF,   15'h3FFF,   16'd0,     1'b0, none},
      '{15'h4000,   15'h4000,   16'd0,     1'b0, none},
      '{15'h3FFF,   15'h4000,   16'd65535, 1'b0, none},
      '{15'h4000,   15'h3FFF,   16'd8191,  1'b0, none},
      '{15'd1000,   15'd0,      16'd8192,  1'b0, none},
      '{15'h7C18,   15'd0,      16'd16384, 1'b0, none},
      '{15'h3FFF,   15'd0,      16'd49152, 1'b0, none},
      '{15'h4000,   15'd0,      16'd21845, 1'b0, none},
      '{15'd0,      15'd2000,   16'd0,     1'b0, none},
      '{15'd0,      15'h7830,   16'd10923, 1'b0, none},
      '{15'd2000,   15'd2000,   16'd24576, 1'b0, none},
      '{15'd1,      15'd1,      16'd40960, 1'b0, none},
      '{15'h7FFF,   15'h7FFF,   16'd57344, 1'b0, none},
      '{15'd3000,   15'd500,    16'd32767, 1'b0, none},
      '{15'd500,    15'd3000,   16'd16383, 1'b0, none},
      '{15'd12000,  15'd9000,   16'd5000,  1'b0, none},
      '{15'h5000,   15'd8000,   16'd45000, 1'b0, none},
      '{15'd0,      15'h4000,   16'd8192,  1'b0, none},
      '{15'd0,      15'h3FFF,   16'd24576, 1'b0, none}
    };
    supplies = '{svpd_pkg::SUPPLY_RESET, 14'd16383, 14'd1, 14'd0, 14'd4096, 14'd9000};
    modes    = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      in_tvalid <= 1'b0;
      drain_results();
      write_supply(ph == 5 ? 14'($urandom_range(1, 16383)) : supplies[ph]);
      idle_mode = modes[ph];
      if (ph == 0) begin
        foreach (dir_rows[i])
          send_word(dir_rows[i].q, dir_rows[i].d, dir_rows[i].a, dir_rows[i].fixed,
                    dir_rows[i].res);
      end
      for (int n = 0; n < 75; n++) begin
        // Fill the pipeline against a stalled receiver once.
        if (ph == 4 && n == 5) hold_go = 1'b1;
        // And once stop sending until every result is back.
        if (ph == 1 && n == 40) begin
          in_tvalid <= 1'b0;
          while (duty_expect_q.size() != 0) @(posedge clk);
        end
        random_word(rq, rd, ra);
        send_word(rq, rd, ra, 1'b0, none);
      end
    end
    in_tvalid <= 1'b0;
    idle_mode = IDLE_NONE;
    drain_results();

    if (fail_count == 0 && duty_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
